// ----- rtl/core/rpb_pkg.sv -----
// Shared types and constants for the RGB pixel blend unit.
// Used by rpb_chan and rgb_pixel_blend_unit; depends on nothing else.
package rpb_pkg;

	localparam int unsigned ChanW = 8;
	localparam int unsigned WeightW = 9;

	typedef enum logic [3:0] {
		MODE_ADD    = 4'd0,
		MODE_SUB    = 4'd1,
		MODE_MUL    = 4'd2,
		MODE_DIFF   = 4'd3,
		MODE_MAX    = 4'd4,
		MODE_MIN    = 4'd5,
		MODE_ALPHA  = 4'd6,
		MODE_INVERT = 4'd7,
		MODE_GRAY   = 4'd8,
		MODE_SWIRL  = 4'd9,
		MODE_KEY    = 4'd10
	} mode_t;

	typedef enum logic [1:0] {
		CFG_BLEND_MODE   = 2'd0,
		CFG_ALPHA_WEIGHT = 2'd1
	} cfg_idx_t;

	localparam logic [ChanW-1:0]   CHAN_MAX  = 8'd255;
	localparam logic [ChanW-1:0]   KEY_LOW   = 8'd10;
	localparam logic [ChanW-1:0]   KEY_HIGH  = 8'd250;
	localparam logic [WeightW-1:0] ALPHA_ONE = 9'd256;

	// Q0.16 luma weights, summing to one.
	localparam logic [15:0] LUMA_R = 16'd13933;
	localparam logic [15:0] LUMA_G = 16'd46871;
	localparam logic [15:0] LUMA_B = 16'd4732;

	// Per-channel partial results handed from the product stage to the final stage.
	typedef struct packed {
		logic [ChanW-1:0] simple;   // result of the modes that need no product
		logic [15:0]      mul_p;    // raw A*B
		logic [16:0]      alp_a;    // A*(256-w)
		logic [16:0]      alp_b;    // B*w
	} chan_s2_t;

endpackage

// ----- rtl/core/rpb_chan.sv -----
// One color channel of the blend datapath: products and the simple per-channel modes.
// Depends on rpb_pkg.
module rpb_chan
	import rpb_pkg::*;
(
	input  mode_t              mode,
	input  logic [ChanW-1:0]   a,
	input  logic [ChanW-1:0]   b,
	input  logic [WeightW-1:0] w,
	output chan_s2_t           res
);

	logic [ChanW:0]     sum;
	logic               a_gt_b;
	logic [ChanW-1:0]   a_minus_b;
	logic [ChanW-1:0]   b_minus_a;
	logic [WeightW-1:0] w_inv;
	logic [ChanW-1:0]   simple;
	logic [15:0]        mul_p;
	logic [16:0]        alp_a;
	logic [16:0]        alp_b;

	assign sum       = {1'b0, a} + {1'b0, b};
	assign a_gt_b    = a > b;
	assign a_minus_b = a - b;
	assign b_minus_a = b - a;
	assign w_inv     = ALPHA_ONE - w;

	assign mul_p = {8'd0, a} * {8'd0, b};
	assign alp_a = {9'd0, a} * {8'd0, w_inv};
	assign alp_b = {9'd0, b} * {8'd0, w};

	always_comb begin
		case (mode)
			MODE_ADD:    simple = sum[ChanW] ? CHAN_MAX : sum[ChanW-1:0];
			MODE_SUB:    simple = a_gt_b ? a_minus_b : '0;
			MODE_DIFF:   simple = a_gt_b ? a_minus_b : b_minus_a;
			MODE_MAX:    simple = a_gt_b ? a : b;
			MODE_MIN:    simple = (a < b) ? a : b;
			MODE_INVERT: simple = CHAN_MAX - a;
			default:     simple = a;
		endcase
	end

	// Members in declaration order, simple in the top bits.
	assign res = {simple, mul_p, alp_a, alp_b};

endmodule

// ----- rtl/core/rgb_pixel_blend_unit.sv -----
// RGB pixel blend unit: three-stage pipeline, one pixel pair per clock while the output is taken.
// An accepted request moves through stages 1 and 2 into the output register, where
// m_tvalid marks its result until it is taken.
// Throughput: one pair per cycle; each stage holds when the stage after it is full and stalled.
// Reset (arst_n low, asynchronous) empties the pipeline and clears both registers to zero.
// Depends on rpb_pkg and rpb_chan.
module rgb_pixel_blend_unit
	import rpb_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	// Input pixel pairs.
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,   // a_red, a_green, a_blue, b_red, b_green, b_blue
	// Result pixels.
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // out_red, out_green, out_blue
	// Register writes.
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [8:0]  cfg_data
);

	// Configuration registers. Writes are always taken; unknown indexes are dropped.
	mode_t              mode_q;
	logic [WeightW-1:0] alpha_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_ADD;
			alpha_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_BLEND_MODE:   mode_q  <= mode_t'(cfg_data[3:0]);
				CFG_ALPHA_WEIGHT: alpha_q <= cfg_data;
				default:          ;
			endcase
		end
	end

	// Stage advance: a stage loads when it is empty or the stage after it moves on.
	// This lets bubbles collapse, so input keeps flowing while the output waits.
	logic v_s1, v_s2, v_s3;
	logic adv1, adv2, adv3;

	assign adv3     = !v_s3 || m_tready;
	assign adv2     = !v_s2 || adv3;
	assign adv1     = !v_s1 || adv2;
	assign s_tready = adv1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (adv1) v_s1 <= s_tvalid;
			if (adv2) v_s2 <= v_s1;
			if (adv3) v_s3 <= v_s2;
		end
	end

	// Stage 1: capture the pixel pair together with the mode and the clamped weight,
	// so every item carries the settings it was accepted under.
	logic [ChanW-1:0]   a_s1 [3];
	logic [ChanW-1:0]   b_s1 [3];
	mode_t              mode_s1;
	logic [WeightW-1:0] w_s1;

	always_ff @(posedge clk) begin
		if (adv1 && s_tvalid) begin
			for (int i = 0; i < 3; i++) begin
				a_s1[i] <= s_tdata[i*ChanW +: ChanW];
				b_s1[i] <= s_tdata[(i+3)*ChanW +: ChanW];
			end
			mode_s1 <= mode_q;
			// A weight above one blends fully to B.
			w_s1    <= (alpha_q > ALPHA_ONE) ? ALPHA_ONE : alpha_q;
		end
	end

	// Stage 2: all multiplications, the simple modes and the chroma-key test.
	chan_s2_t chan_c [3];

	for (genvar g = 0; g < 3; g++) begin : g_chan
		rpb_chan u_chan (
			.mode (mode_s1),
			.a    (a_s1[g]),
			.b    (b_s1[g]),
			.w    (w_s1),
			.res  (chan_c[g])
		);
	end

	logic keyed_c;
	assign keyed_c = (a_s1[0] < KEY_LOW) && (a_s1[2] < KEY_LOW) && (a_s1[1] > KEY_HIGH);

	chan_s2_t         chan_s2 [3];
	logic [ChanW-1:0] a_s2 [3];
	logic [ChanW-1:0] b_s2 [3];
	mode_t            mode_s2;
	logic             keyed_s2;
	logic [23:0]      luma_r_s2, luma_g_s2, luma_b_s2;

	always_ff @(posedge clk) begin
		if (adv2 && v_s1) begin
			for (int i = 0; i < 3; i++) begin
				chan_s2[i] <= chan_c[i];
				a_s2[i]    <= a_s1[i];
				b_s2[i]    <= b_s1[i];
			end
			mode_s2   <= mode_s1;
			keyed_s2  <= keyed_c;
			luma_r_s2 <= {16'd0, a_s1[0]} * {8'd0, LUMA_R};
			luma_g_s2 <= {16'd0, a_s1[1]} * {8'd0, LUMA_G};
			luma_b_s2 <= {16'd0, a_s1[2]} * {8'd0, LUMA_B};
		end
	end

	// Stage 3: sums, clamps and the final selection into the output register.
	// The luma sum never exceeds 255 << 16 and the alpha sum never exceeds 255 << 8,
	// so the upper slices need no clamp.
	logic [25:0]      luma_sum;
	logic [ChanW-1:0] gray;
	logic [ChanW-1:0] res_c [3];
	logic [17:0]      alp_sum [3];

	assign luma_sum = {2'b0, luma_r_s2} + {2'b0, luma_g_s2} + {2'b0, luma_b_s2};
	assign gray     = luma_sum[23:16];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			alp_sum[i] = {1'b0, chan_s2[i].alp_a} + {1'b0, chan_s2[i].alp_b};
			case (mode_s2)
				MODE_MUL:   res_c[i] = (chan_s2[i].mul_p > {8'd0, CHAN_MAX}) ?
				                       CHAN_MAX : chan_s2[i].mul_p[ChanW-1:0];
				MODE_ALPHA: res_c[i] = alp_sum[i][15:8];
				MODE_GRAY:  res_c[i] = gray;
				MODE_SWIRL: res_c[i] = a_s2[(i + 1) % 3];
				MODE_KEY:   res_c[i] = keyed_s2 ? b_s2[i] : a_s2[i];
				default:    res_c[i] = chan_s2[i].simple;
			endcase
		end
	end

	logic [ChanW-1:0] out_s3 [3];

	always_ff @(posedge clk) begin
		if (adv3 && v_s2) begin
			for (int i = 0; i < 3; i++) begin
				out_s3[i] <= res_c[i];
			end
		end
	end

	assign m_tvalid = v_s3;
	assign m_tdata  = {out_s3[2], out_s3[1], out_s3[0]};

	// The input side is only held off when every stage holds an item.
	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (v_s1 && v_s2 && v_s3))
		else $error("input stalled with an empty stage");

	// An item in stage 2 reaches the output when the output stage can take it.
	a_s2_to_out: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s2 && adv3) |=> m_tvalid)
		else $error("item lost between stage 2 and output");

	// Invert of A in the red channel lands in the output exactly.
	a_invert: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s2 && adv3 && mode_s2 == MODE_INVERT) |=>
		(m_tdata[7:0] == ~$past(a_s2[0])))
		else $error("invert result wrong");

endmodule

// ----- bench/rgb_pixel_blend_unit_check.sv -----
// Result checker for the RGB pixel blend unit: tracks register writes, predicts each
// result pixel from the accepted pixel pairs, and compares what the block returns.
// Depends on rpb_pkg for widths, mode codes, register indexes and blend constants.
module rgb_pixel_blend_unit_check
	import rpb_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [47:0] s_tdata,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [23:0] m_tdata,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [8:0]  cfg_data,
	input  logic        run_over,
	output int unsigned pending_n,
	output int unsigned fail_n
);
	timeunit 1ns;
	timeprecision 1ps;

	// Red sits in the low byte, as on both data buses.
	typedef struct packed {
		logic [ChanW-1:0] blue;
		logic [ChanW-1:0] green;
		logic [ChanW-1:0] red;
	} rgb_pix_t;

	logic [3:0]         mode_q;
	logic [WeightW-1:0] weight_q;
	rgb_pix_t           due_pixels[$];
	bit                 leftover_told;

	initial begin
		pending_n = 0;
		fail_n = 0;
	end

	function automatic rgb_pix_t blend_pixel(input logic [3:0] mode,
		input logic [WeightW-1:0] weight, input rgb_pix_t a, input rgb_pix_t b);
		logic [ChanW-1:0] a_ch[3];
		logic [ChanW-1:0] b_ch[3];
		logic [ChanW-1:0] o_ch[3];
		int unsigned w;
		int unsigned av;
		int unsigned bv;
		int unsigned v;
		a_ch = '{a.red, a.green, a.blue};
		b_ch = '{b.red, b.green, b.blue};
		o_ch = a_ch;
		// Weights above one count as exactly one.
		w = (weight > ALPHA_ONE) ? int'(ALPHA_ONE) : int'(weight);
		case (mode)
			MODE_GRAY: begin
				v = (int'(LUMA_R) * int'(a.red) + int'(LUMA_G) * int'(a.green)
					+ int'(LUMA_B) * int'(a.blue)) >> 16;
				if (v > CHAN_MAX)
					v = CHAN_MAX;
				o_ch = '{ChanW'(v), ChanW'(v), ChanW'(v)};
			end
			MODE_SWIRL: o_ch = '{a.green, a.blue, a.red};
			MODE_KEY: begin
				if (a.red < KEY_LOW && a.blue < KEY_LOW && a.green > KEY_HIGH)
					o_ch = b_ch;
			end
			default: begin
				for (int i = 0; i < 3; i++) begin
					av = a_ch[i];
					bv = b_ch[i];
					case (mode)
						MODE_ADD:    v = av + bv;
						MODE_SUB:    v = (av > bv) ? av - bv : 0;
						MODE_MUL:    v = av * bv;
						MODE_DIFF:   v = (av > bv) ? av - bv : bv - av;
						MODE_MAX:    v = (av > bv) ? av : bv;
						MODE_MIN:    v = (av < bv) ? av : bv;
						MODE_ALPHA:  v = (av * (256 - w) + bv * w) >> 8;
						MODE_INVERT: v = CHAN_MAX - av;
						default:     v = av;
					endcase
					o_ch[i] = (v > CHAN_MAX) ? CHAN_MAX : ChanW'(v);
				end
			end
		endcase
		return {o_ch[2], o_ch[1], o_ch[0]};
	endfunction

	// Only the first few dozen failures are printed; all of them are counted.
	task automatic report(input string what);
		fail_n++;
		if (fail_n <= 40)
			$display("%0t ns  mismatch: %s", $realtime, what);
	endtask

	always @(posedge clk or negedge arst_n) begin
		rgb_pix_t want;
		rgb_pix_t got;
		string bad;
		if (!arst_n) begin
			mode_q = '0;
			weight_q = '0;
			due_pixels.delete();
			leftover_told = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == CFG_BLEND_MODE)
					mode_q = cfg_data[3:0];
				else if (cfg_index == CFG_ALPHA_WEIGHT)
					weight_q = cfg_data;
			end
			if (s_tvalid && s_tready)
				due_pixels.push_back(blend_pixel(mode_q, weight_q, s_tdata[23:0],
					s_tdata[47:24]));
			if (m_tvalid && m_tready) begin
				if (due_pixels.size() == 0) begin
					report($sformatf("result pixel %h with no request outstanding", m_tdata));
				end else begin
					want = due_pixels.pop_front();
					got = m_tdata;
					bad = "";
					if (got.red !== want.red)
						bad = {bad, $sformatf(" red %0d want %0d", got.red, want.red)};
					if (got.green !== want.green)
						bad = {bad, $sformatf(" green %0d want %0d", got.green, want.green)};
					if (got.blue !== want.blue)
						bad = {bad, $sformatf(" blue %0d want %0d", got.blue, want.blue)};
					if (bad != "")
						report($sformatf("mode %0d weight %0d:%s", mode_q, weight_q, bad));
				end
			end
			if (run_over && !leftover_told && due_pixels.size() != 0) begin
				leftover_told = 1;
				report($sformatf("%0d result pixels never arrived", due_pixels.size()));
			end
		end
		pending_n = due_pixels.size();
	end

endmodule

// ----- bench/rgb_pixel_blend_unit_test.sv -----
// Top of the RGB pixel blend unit testbench: clock, reset, request stimulus and verdict.
// Depends on rpb_pkg, the block rgb_pixel_blend_unit and the checker module
// rgb_pixel_blend_unit_check, which does all prediction and comparison.
module rgb_pixel_blend_unit_test;
	timeunit 1ns;
	timeprecision 1ps;

	import rpb_pkg::*;

	// Far above the slowest correct run: about 1000 requests, each with a possible longest
	// source gap and sink stall, plus register writes per phase.
	localparam int unsigned CYCLE_LIMIT = 200000;
	localparam int unsigned RANDOM_PHASES = 30;
	// The closing phases run with no idling on either side.
	localparam int unsigned QUIET_PHASES = 5;

	// Mode codes with no operation behind them; the block passes pixel A through.
	localparam logic [3:0] MODE_SPARE_FIRST = 4'd11;
	localparam logic [3:0] MODE_SPARE_LAST  = 4'd15;
	// Register indexes that map to nothing; writes to them must change nothing.
	localparam logic [1:0] CFG_SPARE_LO = 2'd2;
	localparam logic [1:0] CFG_SPARE_HI = 2'd3;

	// Red sits in the low byte, as on both data buses.
	typedef struct packed {
		logic [ChanW-1:0] blue;
		logic [ChanW-1:0] green;
		logic [ChanW-1:0] red;
	} rgb_pix_t;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic [47:0] s_tdata = '0;
	logic        m_tready = 1'b0;
	logic        cfg_valid = 1'b0;
	logic [1:0]  cfg_index = '0;
	logic [8:0]  cfg_data = '0;
	logic        run_over = 1'b0;
	wire         s_tready;
	wire         m_tvalid;
	wire  [23:0] m_tdata;
	wire         cfg_ready;
	int unsigned pending_n;
	int unsigned fail_n;
	int unsigned cycle_n = 0;
	bit          idle_on = 1'b1;

	rgb_pixel_blend_unit i_dut (.*);

	rgb_pixel_blend_unit_check i_check (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Watchdog: a hung handshake ends the run as a failure.
	always @(posedge clk) begin
		cycle_n <= cycle_n + 1;
		if (cycle_n == CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// Result sink. Ready drops for random bursts while idling is on,
	// and stays high otherwise. Each branch touches m_tready at most once per edge.
	initial begin
		forever begin
			@(negedge clk);
			if (idle_on && arst_n && $urandom_range(0, 5) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 12)) @(negedge clk);
			end
			m_tready <= 1'b1;
		end
	end

	function automatic rgb_pix_t px(input logic [7:0] r, input logic [7:0] g,
		input logic [7:0] b);
		return {b, g, r};
	endfunction

	// Channel values lean toward the saturation points 0 and 255.
	function automatic logic [7:0] rand_chan();
		case ($urandom_range(0, 7))
			0:       return 8'd0;
			1:       return 8'd255;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	function automatic rgb_pix_t rand_pixel();
		return px(rand_chan(), rand_chan(), rand_chan());
	endfunction

	// Pixels around the green-screen window, with red and blue straddling the low
	// threshold and green straddling the high one.
	function automatic rgb_pix_t key_pixel();
		return px(8'($urandom_range(0, 11)), 8'($urandom_range(248, 255)),
			8'($urandom_range(0, 11)));
	endfunction

	// One register write request; called at a falling edge, returns at one.
	task automatic write_reg(input logic [1:0] idx, input logic [8:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// One pixel pair request, preceded now and then by a source gap. Valid stays
	// high between back-to-back requests; it is only lowered for a gap or when sending stops.
	task automatic push_pair(input rgb_pix_t a, input rgb_pix_t b);
		if (idle_on && $urandom_range(0, 5) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {b, a};
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
	endtask

	// Stop sending and wait until every predicted result pixel has come back.
	// Every request yields a result, so the pipeline is empty at that point.
	task automatic settle();
		s_tvalid <= 1'b0;
		while (pending_n != 0) @(negedge clk);
	endtask

	// Registers are only rewritten with the block idle. The mode write carries
	// random upper data bits, which the four-bit mode register must drop.
	task automatic set_regs(input logic [3:0] mode, input logic [8:0] weight);
		settle();
		write_reg(CFG_BLEND_MODE, {5'($urandom_range(0, 31)), mode});
		write_reg(CFG_ALPHA_WEIGHT, weight);
	endtask

	initial begin
		logic [8:0]  alpha_steps[4];
		logic [8:0]  weight_marks[6];
		logic [3:0]  mode;
		logic [8:0]  weight;
		int unsigned n_items;
		rgb_pix_t    a_px;

		alpha_steps = '{9'd0, 9'd128, 9'd256, 9'd511};
		weight_marks = '{9'd0, 9'd1, 9'd255, 9'd256, 9'd257, 9'd511};

		repeat (6) @(negedge clk);
		arst_n <= 1'b1;

		// Directed pixels. Each one mixes saturating, exact and zero channels so a
		// single request covers several corners of its operation.
		set_regs(MODE_ADD, 9'd0);
		push_pair(px(8'hff, 8'h80, 8'h00), px(8'h01, 8'h7f, 8'h00));
		set_regs(MODE_SUB, 9'd0);
		push_pair(px(8'h00, 8'hff, 8'h80), px(8'hff, 8'h00, 8'h80));
		set_regs(MODE_MUL, 9'd0);
		push_pair(px(8'hff, 8'h10, 8'h01), px(8'hff, 8'h0f, 8'hff));
		set_regs(MODE_DIFF, 9'd0);
		push_pair(px(8'h00, 8'hff, 8'h37), px(8'hff, 8'h00, 8'h99));
		set_regs(MODE_MAX, 9'd0);
		push_pair(px(8'h00, 8'hff, 8'h40), px(8'hff, 8'h00, 8'h40));
		set_regs(MODE_MIN, 9'd0);
		push_pair(px(8'h00, 8'hff, 8'h40), px(8'hff, 8'h00, 8'h40));

		// Alpha at zero, one half, exactly one, and a weight above one that must
		// behave as one.
		foreach (alpha_steps[i]) begin
			set_regs(MODE_ALPHA, alpha_steps[i]);
			push_pair(px(8'hff, 8'h00, 8'h80), px(8'h00, 8'hff, 8'h7f));
		end

		// Invert, gray and swirl read only pixel A, so B is left random.
		set_regs(MODE_INVERT, 9'h1a5);
		push_pair(px(8'h00, 8'hff, 8'h5a), rand_pixel());
		set_regs(MODE_GRAY, 9'd0);
		push_pair(px(8'hff, 8'hff, 8'hff), rand_pixel());
		push_pair(px(8'h00, 8'h00, 8'h00), rand_pixel());
		set_regs(MODE_SWIRL, 9'd0);
		push_pair(px(8'h11, 8'h22, 8'h33), rand_pixel());

		// Green screen: two keyed pixels, then one step past each threshold.
		set_regs(MODE_KEY, 9'd0);
		push_pair(px(8'd9, 8'd251, 8'd9), px(8'h12, 8'h34, 8'h56));
		push_pair(px(8'd0, 8'd255, 8'd0), px(8'hff, 8'h00, 8'hff));
		push_pair(px(8'd10, 8'd255, 8'd0), px(8'h12, 8'h34, 8'h56));
		push_pair(px(8'd0, 8'd250, 8'd0), px(8'h12, 8'h34, 8'h56));
		push_pair(px(8'd0, 8'd255, 8'd10), px(8'h12, 8'h34, 8'h56));

		// The first and last unassigned mode codes.
		set_regs(MODE_SPARE_FIRST, 9'd511);
		push_pair(px(8'h01, 8'h80, 8'hfe), rand_pixel());
		set_regs(MODE_SPARE_LAST, 9'd0);
		push_pair(px(8'hfe, 8'h7f, 8'h01), rand_pixel());

		// Random phases: one register setting each, then a burst of pixel pairs.
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			settle();
			idle_on = (p < RANDOM_PHASES - QUIET_PHASES);
			if ($urandom_range(0, 3) == 0)
				mode = 4'($urandom_range(0, 15));
			else
				mode = 4'($urandom_range(MODE_ADD, MODE_KEY));
			if ($urandom_range(0, 3) == 0)
				weight = weight_marks[$urandom_range(0, 5)];
			else
				weight = 9'($urandom_range(0, 511));
			set_regs(mode, weight);
			if ($urandom_range(0, 4) == 0)
				write_reg($urandom_range(0, 1) ? CFG_SPARE_HI : CFG_SPARE_LO,
					9'($urandom_range(0, 511)));
			n_items = $urandom_range(20, 44);
			for (int i = 0; i < n_items; i++) begin
				// In key mode half the pixels sit near the key window; uniform
				// random pixels would almost never hit it.
				if (mode == MODE_KEY && $urandom_range(0, 1) == 1)
					a_px = key_pixel();
				else
					a_px = rand_pixel();
				push_pair(a_px, rand_pixel());
			end
		end

		settle();
		// Wait on to catch any stray result after the pipeline drains.
		repeat (8) @(negedge clk);
		run_over <= 1'b1;
		@(posedge clk);
		@(negedge clk);
		if (fail_n == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
